// ===== sv/hcd_pkg.sv =====
// hcd_pkg: widths, register indexes and payload types for the hill-car step
// no dependencies
`default_nettype none
package hcd_pkg;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;
    localparam logic [CfgIdxW-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GRAVITY = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_POS_MIN = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_POS_MAX = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_VEL_MIN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_VEL_MAX = 3'd5;
    localparam int SqrtW = 36;
    localparam int SlopeThresh = 6554;
    // square root side data: h, g*s, position, velocity, drive
    localparam int SqSideW = 36 + 42 + 96;
    // dividers: 64 bit dividend, widest divisor is h, side data of the first one
    localparam int DivNumW = 64;
    localparam int DivDenW = 36;
    localparam int DivSideW = 36 + 42 + 64;

    typedef struct packed {
        logic signed [31:0] pos_in;
        logic signed [31:0] vel_in;
        logic signed [31:0] drive_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_out;
        logic signed [31:0] vel_out;
        logic clamped;
    } out_item_t;

    typedef struct packed {
        logic [20:0] time_step;
        logic [21:0] gravity;
        logic signed [31:0] pos_min;
        logic signed [31:0] pos_max;
        logic signed [31:0] vel_min;
        logic signed [31:0] vel_max;
    } cfg_t;
endpackage
`default_nettype wire

// ===== sv/hcd_in_if.sv =====
// hcd_in_if: request channel carrying one car state and drive
// depends on hcd_pkg
`default_nettype none
interface hcd_in_if;
    import hcd_pkg::*;
    logic valid;
    logic ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/hcd_out_if.sv =====
// hcd_out_if: result channel carrying the next car state
// depends on hcd_pkg
`default_nettype none
interface hcd_out_if;
    import hcd_pkg::*;
    logic valid;
    logic ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/hcd_divider.sv =====
// hcd_divider: pipelined signed restoring divider, one quotient bit per stage
// depends on hcd_pkg; quotient truncated toward zero
`default_nettype none
module hcd_divider
    import hcd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic signed [DivNumW-1:0] num,
    input  wire logic [DivDenW-1:0]        den,
    input  wire logic [DivSideW-1:0]       side_in,
    output logic                           out_valid,
    output logic signed [DivNumW-1:0]      quo,
    output logic [DivSideW-1:0]            side_out
);
    logic [DivNumW:0]      valid_reg;
    logic [DivNumW-1:0]    q_reg [DivNumW+1];
    logic [DivDenW:0]      rem_reg [DivNumW+1];
    logic [DivDenW-1:0]    den_reg [DivNumW+1];
    logic                  neg_reg [DivNumW+1];
    logic [DivSideW-1:0]   side_reg [DivNumW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DivNumW-1:0], in_valid};
    end

    // stage 0 takes magnitude; each stage after produces one quotient bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= num[DivNumW-1] ? DivNumW'(-num) : DivNumW'(num);
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[DivNumW-1];
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < DivNumW; k++)
    begin : g_stage
        logic [DivDenW:0] trial;
        logic [DivDenW+1:0] diff;
        assign trial = {rem_reg[k][DivDenW-1:0], q_reg[k][DivNumW-1]};
        assign diff = {1'b0, trial} - {2'b00, den_reg[k]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[DivDenW+1])
                begin
                    rem_reg[k+1] <= diff[DivDenW:0];
                    q_reg[k+1] <= {q_reg[k][DivNumW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= trial;
                    q_reg[k+1] <= {q_reg[k][DivNumW-2:0], 1'b0};
                end
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[DivNumW];
    assign quo = neg_reg[DivNumW] ? DivNumW'(-q_reg[DivNumW]) : DivNumW'(q_reg[DivNumW]);
    assign side_out = side_reg[DivNumW];
endmodule
`default_nettype wire

// ===== sv/hcd_sqrt.sv =====
// hcd_sqrt: pipelined integer square root, one result bit per stage
// depends on hcd_pkg (SqrtW, SqSideW)
`default_nettype none
module hcd_sqrt
    import hcd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [SqrtW-1:0]   rad,
    input  wire logic [SqSideW-1:0] side_in,
    output logic                    out_valid,
    output logic [SqrtW/2-1:0]      root,
    output logic [SqSideW-1:0]      side_out
);
    localparam int N = SqrtW / 2;
    logic [N:0]         valid_reg;
    logic [SqrtW-1:0]   x_reg [N+1];
    logic [N+1:0]       rem_reg [N+1];
    logic [N-1:0]       r_reg [N+1];
    logic [SqSideW-1:0] side_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= rad;
            rem_reg[0] <= '0;
            r_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [N+1:0] trial;
        logic [N+1:0] sub;
        assign trial = {rem_reg[k][N-1:0], x_reg[k][SqrtW-1 -: 2]};
        assign sub = {r_reg[k], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1] <= {x_reg[k][SqrtW-3:0], 2'b00};
                side_reg[k+1] <= side_reg[k];
                if (trial >= sub)
                begin
                    rem_reg[k+1] <= trial - sub;
                    r_reg[k+1] <= {r_reg[k][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= trial;
                    r_reg[k+1] <= {r_reg[k][N-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign root = r_reg[N];
    assign side_out = side_reg[N];
endmodule
`default_nettype wire

// ===== sv/hill_car_dynamics_step.sv =====
// hill_car_dynamics_step: top level, slope, sqrt, dividers, integration, clamp
// depends on hcd_pkg, hcd_in_if, hcd_out_if, hcd_sqrt, hcd_divider
//
//  channel  dir  payload                    handshake
//  req      in   pos_in, vel_in, drive_in   valid/ready
//  rsp      out  pos_out, vel_out, clamped  valid/ready
//  cfg      in   index, data                write enable only
//
// one request per cycle while the result side does not stall; 155 register stages
// in all, including the pipelined square root (19 stages) and the two
// 65-stage dividers in sequence.
// the whole pipe advances together when the output register is free or taken.
// reset clears all valid bits and loads the register defaults.
`default_nettype none
module hill_car_dynamics_step
    import hcd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    hcd_in_if.sink                   req,
    hcd_out_if.source                rsp,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);
    cfg_t cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step <= 21'd3277;
            cfg_reg.gravity <= 22'd642646;
            cfg_reg.pos_min <= -32'sd393216;
            cfg_reg.pos_max <= 32'sd393216;
            cfg_reg.vel_min <= -32'sd327680;
            cfg_reg.vel_max <= 32'sd327680;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP: cfg_reg.time_step <= cfg_data[20:0];
                REG_GRAVITY:   cfg_reg.gravity <= cfg_data[21:0];
                REG_POS_MIN:   cfg_reg.pos_min <= cfg_data;
                REG_POS_MAX:   cfg_reg.pos_max <= cfg_data;
                REG_VEL_MIN:   cfg_reg.vel_min <= cfg_data;
                REG_VEL_MAX:   cfg_reg.vel_max <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // stage 1: slope
    logic [18:0] u;
    logic signed [19:0] r;
    logic [18:0] mag;
    logic signed [19:0] w;
    logic [18:0] aw;
    logic signed [19:0] m;
    always_comb
    begin
        u = 19'(req.data.pos_in + 32'sd131072);
        r = $signed({1'b0, u}) - 20'sd262144;
        mag = r[19] ? 19'(-r) : 19'(r);
        w = $signed({1'b0, mag}) - 20'sd131072;
        aw = w[19] ? 19'(-w) : 19'(w);
        m = $signed({1'b0, aw}) - 20'(SlopeThresh);
        if (m[19])
            m = '0;
    end

    logic v1_reg;
    logic signed [18:0] s1_reg;
    logic signed [31:0] p1_reg, v1d_reg, d1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= req.valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= w[19] ? 19'(-m) : 19'(m);
            p1_reg <= req.data.pos_in;
            v1d_reg <= req.data.vel_in;
            d1_reg <= req.data.drive_in;
        end
    end

    // stage 2: h = 2^34 + s*s
    logic v2_reg;
    logic signed [18:0] s2_reg;
    logic [35:0] h2_reg;
    logic signed [31:0] p2_reg, v2d_reg, d2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s1_reg;
            h2_reg <= 36'h400000000 + 36'($unsigned(38'(s1_reg) * 38'(s1_reg)));
            p2_reg <= p1_reg;
            v2d_reg <= v1d_reg;
            d2_reg <= d1_reg;
        end
    end

    // g*s product in parallel, registered
    logic signed [41:0] gs3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            gs3_reg <= 42'($signed({1'b0, cfg_reg.gravity})) * 42'(s1_reg);
    end

    // square root, carries h, g*s and state
    logic sq_valid;
    logic [17:0] q_root;
    logic [SqSideW-1:0] sq_side;
    hcd_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2_reg), .rad(h2_reg),
        .side_in({h2_reg, gs3_reg, p2_reg, v2d_reg, d2_reg}),
        .out_valid(sq_valid), .root(q_root), .side_out(sq_side)
    );
    logic [35:0] h_s;
    logic signed [41:0] gs_s;
    logic signed [31:0] p_s, v_s, d_s;
    assign {h_s, gs_s, p_s, v_s, d_s} = sq_side;

    // term1 = drive*2^17/q, carrying term2 operands
    logic t1_valid;
    logic signed [63:0] t1_quo;
    logic [DivSideW-1:0] t1_side;
    hcd_divider u_div1 (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sq_valid), .num(64'(d_s) <<< 17), .den({18'd0, q_root}),
        .side_in({h_s, gs_s, p_s, v_s}),
        .out_valid(t1_valid), .quo(t1_quo), .side_out(t1_side)
    );
    logic [35:0] h_t;
    logic signed [41:0] gs_t;
    logic signed [31:0] p_t, v_t;
    assign {h_t, gs_t, p_t, v_t} = t1_side;

    // term2 = g*s*2^17/h
    logic t2_valid;
    logic signed [63:0] t2_quo;
    logic [DivSideW-1:0] t2_side;
    hcd_divider u_div2 (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(t1_valid), .num(64'(gs_t) <<< 17), .den(h_t),
        .side_in({14'd0, t1_quo, p_t, v_t}),
        .out_valid(t2_valid), .quo(t2_quo), .side_out(t2_side)
    );
    logic signed [63:0] t1_q;
    logic signed [31:0] p_q, v_q;
    assign {t1_q, p_q, v_q} = t2_side[127:0];

    // stage a: a = term1 - term2 (fits 34 bits), tt
    logic va_reg;
    logic signed [33:0] a_reg;
    logic signed [31:0] pa_reg, vaa_reg;
    logic [26:0] tt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= t2_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= 34'(t1_q - t2_quo);
            tt_reg <= 27'((42'(cfg_reg.time_step) * 42'(cfg_reg.time_step)
                           + 42'd32768) >> 16);
            pa_reg <= p_q;
            vaa_reg <= v_q;
        end
    end

    // stage b: products t*v, t*a and tt*a
    logic vb_reg;
    logic signed [61:0] tta_reg;
    logic signed [55:0] ta_reg;
    logic signed [53:0] tv_reg;
    logic signed [31:0] pb_reg, vb2_reg;
    logic signed [33:0] a_lo_unused;
    assign a_lo_unused = a_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tta_reg <= 62'($signed({1'b0, tt_reg})) * 62'(a_lo_unused);
            ta_reg <= 56'($signed({1'b0, cfg_reg.time_step})) * 56'(a_reg);
            tv_reg <= 54'($signed({1'b0, cfg_reg.time_step})) * 54'(vaa_reg);
            pb_reg <= pa_reg;
            vb2_reg <= vaa_reg;
        end
    end

    // stage c: accumulate and round
    logic vc_reg;
    logic signed [63:0] np_reg, nv_reg;
    logic signed [80:0] pos_acc, vel_acc;
    always_comb
    begin
        pos_acc = (81'(pb_reg) <<< 16) + 81'(tv_reg) + 81'(tta_reg >>> 1)
                  + 81'sd32768;
        vel_acc = (81'(vb2_reg) <<< 16) + 81'(ta_reg) + 81'sd32768;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            np_reg <= 64'(pos_acc >>> 16);
            nv_reg <= 64'(vel_acc >>> 16);
        end
    end

    // clamp into output register
    out_item_t out_next;
    logic pcl, vcl;
    always_comb
    begin
        out_next.pos_out = 32'(np_reg);
        out_next.vel_out = 32'(nv_reg);
        pcl = 1'b0;
        vcl = 1'b0;
        if (np_reg < 64'(cfg_reg.pos_min))
        begin
            out_next.pos_out = cfg_reg.pos_min;
            pcl = 1'b1;
        end
        else if (np_reg > 64'(cfg_reg.pos_max))
        begin
            out_next.pos_out = cfg_reg.pos_max;
            pcl = 1'b1;
        end
        if (nv_reg < 64'(cfg_reg.vel_min))
        begin
            out_next.vel_out = cfg_reg.vel_min;
            vcl = 1'b1;
        end
        else if (nv_reg > 64'(cfg_reg.vel_max))
        begin
            out_next.vel_out = cfg_reg.vel_max;
            vcl = 1'b1;
        end
        if (pcl)
            out_next.vel_out = '0;
        out_next.clamped = pcl | vcl;
    end

    out_item_t out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vc_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;
endmodule
`default_nettype wire

// ===== dv/hcd_checker.sv =====
// hcd_checker: watches the request, result and register ports of the hill-car step,
// predicts each result in fixed point and compares it field by field
// depends on hcd_pkg, hcd_in_if, hcd_out_if
`default_nettype none
module hcd_checker
    import hcd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    hcd_in_if                        req,
    hcd_out_if                       rsp,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending
);
    cfg_t      regs;
    out_item_t next_states[$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // triangle-wave slope in Q.17, soft threshold around zero
    function automatic longint slope_q17(longint p);
        longint r;
        longint w;
        longint m;
        r = ((p - 131072 + 262144) & 64'd524287) - 262144;
        w = (r < 0 ? -r : r) - 131072;
        m = (w < 0 ? -w : w) - SlopeThresh;
        if (m < 0)
            m = 0;
        return w < 0 ? -m : m;
    endfunction

    function automatic longint round_q16(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic out_item_t next_car_state(in_item_t it);
        out_item_t res;
        longint p, v, d, t, g, s, h, q, acc, tt, np, nv;
        logic pclamp, vclamp;
        p = it.pos_in;
        v = it.vel_in;
        d = it.drive_in;
        t = longint'(regs.time_step);
        g = longint'(regs.gravity);
        s = slope_q17(p);
        h = (64'sd1 <<< 34) + s * s;
        q = longint'(int_sqrt(h));
        acc = (d * 131072) / q - (g * s * 131072) / h;
        tt = round_q16(t * t);
        np = round_q16(p * 65536 + t * v + ((tt * acc) >>> 1));
        nv = round_q16(v * 65536 + t * acc);
        pclamp = 1'b0;
        vclamp = 1'b0;
        if (np < longint'(regs.pos_min))
        begin
            np = regs.pos_min;
            pclamp = 1'b1;
        end
        else if (np > longint'(regs.pos_max))
        begin
            np = regs.pos_max;
            pclamp = 1'b1;
        end
        if (nv < longint'(regs.vel_min))
        begin
            nv = regs.vel_min;
            vclamp = 1'b1;
        end
        else if (nv > longint'(regs.vel_max))
        begin
            nv = regs.vel_max;
            vclamp = 1'b1;
        end
        if (pclamp)
            nv = 0;
        res.pos_out = np[31:0];
        res.vel_out = nv[31:0];
        res.clamped = pclamp | vclamp;
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.time_step <= 21'd3277;
            regs.gravity   <= 22'd642646;
            regs.pos_min   <= -32'sd393216;
            regs.pos_max   <= 32'sd393216;
            regs.vel_min   <= -32'sd327680;
            regs.vel_max   <= 32'sd327680;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIME_STEP: regs.time_step <= cfg_data[20:0];
                    REG_GRAVITY:   regs.gravity   <= cfg_data[21:0];
                    REG_POS_MIN:   regs.pos_min   <= cfg_data;
                    REG_POS_MAX:   regs.pos_max   <= cfg_data;
                    REG_VEL_MIN:   regs.vel_min   <= cfg_data;
                    REG_VEL_MAX:   regs.vel_max   <= cfg_data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                next_states.push_back(next_car_state(req.data));
            if (rsp.valid && rsp.ready)
            begin
                if (next_states.size() == 0)
                    report("unexpected result, pos_out", rsp.data.pos_out, 0);
                else
                begin
                    out_item_t want;
                    want = next_states.pop_front();
                    if (rsp.data.pos_out !== want.pos_out)
                        report("pos_out", rsp.data.pos_out, want.pos_out);
                    if (rsp.data.vel_out !== want.vel_out)
                        report("vel_out", rsp.data.vel_out, want.vel_out);
                    if (rsp.data.clamped !== want.clamped)
                        report("clamped", rsp.data.clamped, want.clamped);
                end
            end
            pending <= next_states.size();
        end
    end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: stimulus and verdict for hill_car_dynamics_step
// depends on hcd_pkg, hcd_in_if, hcd_out_if, hcd_checker and the block itself
`default_nettype none
module testbench;
    import hcd_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    int                  fail_count;
    int                  pending;
    bit                  quiet;
    int                  hold_cycles;

    hcd_in_if  req();
    hcd_out_if rsp();

    hill_car_dynamics_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hcd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #(20 * 1000000);
        $display("Verification failed");
        $finish;
    end

    // result side: random stall bursts plus one long hold-off on request
    initial
    begin
        int burst;
        burst = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                hold_cycles--;
            end
            else if (burst > 0)
            begin
                rsp.ready <= 1'b0;
                burst--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 6) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic send(logic [31:0] p, logic [31:0] v, logic [31:0] d);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= '{pos_in: p, vel_in: v, drive_in: d};
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] t, logic [31:0] g, logic [31:0] pmin,
                            logic [31:0] pmax, logic [31:0] vmin, logic [31:0] vmax);
        wait_idle();
        write_reg(REG_TIME_STEP, t);
        write_reg(REG_GRAVITY, g);
        write_reg(REG_POS_MIN, pmin);
        write_reg(REG_POS_MAX, pmax);
        write_reg(REG_VEL_MIN, vmin);
        write_reg(REG_VEL_MAX, vmax);
    endtask

    // mostly physical states near the hill, sometimes anything
    task automatic random_state();
        logic [31:0] p, v, d;
        if ($urandom_range(0, 3) == 0)
        begin
            p = $urandom;
            v = $urandom;
            d = $urandom;
        end
        else
        begin
            p = $signed($urandom_range(0, 1048576)) - 524288;
            v = $signed($urandom_range(0, 786432)) - 393216;
            d = $signed($urandom_range(0, 262144)) - 131072;
            if ($urandom_range(0, 4) == 0)
                p = 32'sd393216 + $signed($urandom_range(0, 13108)) - 6554;
        end
        send(p, v, d);
    endtask

    initial
    begin
        quiet       = 1'b0;
        hold_cycles = 0;
        rst_n       = 1'b0;
        req.valid   <= 1'b0;
        req.data    <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (3) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // defaults: field extremes, slope flat region and steepest point, states around the position bound
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send(32'h0, 32'h0, 32'h0);
        send(32'd131072, 32'h0, 32'h0);
        send(32'd393216 - 6554, 32'h0, 32'd65536);
        send(32'd393216 + 6554, 32'h0, 32'hffff_0000);
        send(32'd393216, 32'd327680, 32'h0);
        send(32'hfffa_0000, 32'hfffb_0000, 32'h7fff_ffff);
        send(32'h0, 32'h0, 32'h8000_0000);

        // zero step: state passes through, equality with bounds is not clamped
        set_regs(32'd0, 32'd642646, -32'sd393216, 32'sd393216, -32'sd327680, 32'sd327680);
        send(32'd393216, 32'd327680, 32'd0);
        send(32'd393217, 32'd0, 32'd0);
        send(-32'sd393216, -32'sd327680, 32'd0);
        send(-32'sd393217, 32'd5, 32'd0);
        send(32'd0, 32'd327681, 32'd0);
        send(32'd0, -32'sd327681, 32'd0);

        // inverted bounds, and 0 outside the velocity box
        set_regs(32'd0, 32'd0, 32'sd65536, -32'sd65536, 32'sd65536, 32'sd131072);
        send(32'd0, 32'd0, 32'd0);
        send(32'sd131072, 32'sd100000, 32'd0);
        send(-32'sd131072, 32'sd100000, 32'd0);

        // step and gravity with only their top bit set, full range box
        set_regs(32'd1048576, 32'd2097152, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send(32'd393216 + 6553, 32'h0, 32'h0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_regs(32'd3277, 32'd642646, -32'sd393216, 32'sd393216,
                            -32'sd327680, 32'sd327680);
                1: set_regs(32'd1, 32'd0, 32'h8000_0000, 32'h7fff_ffff,
                            32'h8000_0000, 32'h7fff_ffff);
                5: set_regs(32'd3277, 32'd642646, -32'sd393216, 32'sd393216,
                            -32'sd327680, 32'sd327680);
                default: set_regs($urandom_range(0, 2097151), $urandom_range(0, 4194303),
                                  $urandom, $urandom, $urandom, $urandom);
            endcase
            if (phase == 5)
                quiet = 1'b1;
            for (int n = 0; n < 160; n++)
            begin
                if (phase == 2 && n == 20)
                    hold_cycles = 300;
                random_state();
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
